/* design/running_box_blur_pixel_line_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the running box blur line core
// Shared concurrent check forms, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef RUNNING_BOX_BLUR_PIXEL_LINE_CORE_ASSERT_SVH
`define RUNNING_BOX_BLUR_PIXEL_LINE_CORE_ASSERT_SVH

// Same-cycle implication.
`define RBB_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define RBB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/rbb_pkg.sv */
// ----------------------------------------------------------------------------
// rbb_pkg
// Widths, register indexes and constants of the running box blur line core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rbb_pkg;

  // Pixel and channel geometry.
  localparam int PIX_W   = 32;
  localparam int CH_W    = 8;
  localparam int NUM_CH  = PIX_W / CH_W;

  // Configuration port.
  localparam int SHIFT_W    = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Alpha is averaged only for windows shorter than 256 pixels.
  localparam int ALPHA_SHIFT_LIMIT = 8;
  localparam int ALPHA_CH          = 3;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLUR_ENABLE  = 2'd0,
    CFG_WINDOW_SHIFT = 2'd1,
    CFG_MASKED_MODE  = 2'd2,
    CFG_PIXEL_MASK   = 2'd3
  } cfg_reg_t;

endpackage

`default_nettype wire

/* design/rbb_in_if.sv */
// ----------------------------------------------------------------------------
// rbb_in_if
// Input pixel channel: valid/ready handshake with pixel and line start flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rbb_in_if import rbb_pkg::*;;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_in;
  logic             line_start;

  modport source (output valid, output pixel_in, output line_start, input ready);
  modport sink   (input valid, input pixel_in, input line_start, output ready);
endinterface

`default_nettype wire

/* design/rbb_out_if.sv */
// ----------------------------------------------------------------------------
// rbb_out_if
// Output pixel channel: valid/ready handshake with the blurred pixel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rbb_out_if import rbb_pkg::*;;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;

  modport source (output valid, output pixel_out, input ready);
  modport sink   (input valid, input pixel_out, output ready);
endinterface

`default_nettype wire

/* design/rbb_ram.sv */
// ----------------------------------------------------------------------------
// rbb_ram
// Simple dual-port RAM, one write and one registered read port, read-first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rbb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

`default_nettype wire

/* design/running_box_blur_pixel_line_core.sv */
// ----------------------------------------------------------------------------
// running_box_blur_pixel_line_core
// Forward running box blur over one pixel line with a ring buffer in RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on in_chan (valid/ready), the first pixel of each line
//   flagged by line_start. Each accepted beat yields exactly one beat on
//   out_chan; with blur on, the last 2^eff_shift pixels' sum >> eff_shift.
//   Configuration is written through cfg_write/cfg_index/cfg_data while the
//   core is idle.
//   A pixel accepted on in_chan passes the RAM stage and output registers.
//   Throughput: one pixel per clock while out_chan is not stalled; the ring
//   RAM is read and written in the acceptance cycle (read-first); the running
//   sums update when the beat leaves the RAM stage with the evicted pixel.
//   Reset clears configuration, sums, line position and the pipeline; the
//   ring RAM is not cleared and needs none, since every line start refills
//   the window before any entry is evicted.
//   When the receiver stalls, the output register and the RAM stage hold
//   two beats; in_chan.ready then drops until out_chan drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "running_box_blur_pixel_line_core_assert.svh"

module running_box_blur_pixel_line_core import rbb_pkg::*; #(
  parameter int MAX_WINDOW_LOG2 = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  rbb_in_if.sink                     in_chan,
  rbb_out_if.source                  out_chan
);

  localparam int DEPTH  = 1 << MAX_WINDOW_LOG2;
  localparam int POS_W  = MAX_WINDOW_LOG2;
  localparam int CSUM_W = CH_W + MAX_WINDOW_LOG2;
  localparam int MSUM_W = PIX_W + MAX_WINDOW_LOG2;

  // Configuration registers.
  logic               blur_enable;
  logic [SHIFT_W-1:0] window_shift;
  logic               masked_mode;
  logic [PIX_W-1:0]   pixel_mask;

  // Line state.
  logic [POS_W-1:0]  position;
  logic              window_full;
  logic [CSUM_W-1:0] chan_sum [NUM_CH];
  logic [MSUM_W-1:0] masked_sum;

  // RAM stage and output register.
  logic             s1_valid;
  logic [PIX_W-1:0] s1_pixel;
  logic             s1_line_start;
  logic             s1_full;
  logic             s1_enable;
  logic             out_valid;
  logic [PIX_W-1:0] out_pixel;

  logic               in_fire;
  logic               s1_adv;
  logic [SHIFT_W-1:0] eff_shift;
  logic [POS_W-1:0]   win_mask;
  logic [POS_W-1:0]   pos_base;
  logic               full_base;
  logic [POS_W-1:0]   ring_idx;
  logic [PIX_W-1:0]   ring_rdata;
  logic [PIX_W-1:0]   old_pix;
  logic [CSUM_W-1:0]  chan_sum_next [NUM_CH];
  logic [CSUM_W-1:0]  chan_shifted [NUM_CH];
  logic [MSUM_W-1:0]  masked_sum_next;
  logic [MSUM_W-1:0]  masked_shifted;
  logic [PIX_W-1:0]   blur_pixel;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      blur_enable  <= 1'b0;
      window_shift <= '0;
      masked_mode  <= 1'b0;
      pixel_mask   <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_BLUR_ENABLE:  blur_enable  <= cfg_data[0];
        CFG_WINDOW_SHIFT: window_shift <= cfg_data[SHIFT_W-1:0];
        CFG_MASKED_MODE:  masked_mode  <= cfg_data[0];
        CFG_PIXEL_MASK:   pixel_mask   <= cfg_data[PIX_W-1:0];
      endcase
    end
  end

  // Handshakes: the RAM stage moves on whenever the output register is free.
  assign s1_adv        = s1_valid && (!out_valid || out_chan.ready);
  assign in_chan.ready = !s1_valid || s1_adv;
  assign in_fire       = in_chan.valid && in_chan.ready;

  // Window geometry and ring slot of the incoming pixel.
  always_comb begin
    eff_shift = (window_shift > SHIFT_W'(MAX_WINDOW_LOG2)) ?
                SHIFT_W'(MAX_WINDOW_LOG2) : window_shift;
    win_mask  = POS_W'((32'd1 << eff_shift) - 32'd1);
    pos_base  = in_chan.line_start ? '0 : position;
    full_base = in_chan.line_start ? 1'b0 : window_full;
    ring_idx  = pos_base & win_mask;
  end

  // Ring buffer: the evicted pixel is read while the new one is written.
  rbb_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (in_fire && blur_enable),
    .waddr (ring_idx),
    .wdata (in_chan.pixel_in),
    .re    (in_fire && blur_enable),
    .raddr (ring_idx),
    .rdata (ring_rdata)
  );

  // Line position and window fill state advance at acceptance while blur is enabled.
  always_ff @(posedge clk) begin
    if (rst) begin
      position    <= '0;
      window_full <= 1'b0;
    end else if (in_fire && blur_enable) begin
      position    <= pos_base + POS_W'(1);
      window_full <= full_base || (ring_idx == win_mask);
    end
  end

  // RAM stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pixel      <= in_chan.pixel_in;
      s1_line_start <= in_chan.line_start;
      s1_full       <= full_base;
      s1_enable     <= blur_enable;
    end
  end

  // Running sums: drop the evicted pixel, add the new one.
  always_comb begin
    old_pix = s1_full ? ring_rdata : '0;
    for (int c = 0; c < NUM_CH; c++) begin
      chan_sum_next[c] = (s1_line_start ? '0 : chan_sum[c])
                       - CSUM_W'(old_pix[c*CH_W +: CH_W])
                       + CSUM_W'(s1_pixel[c*CH_W +: CH_W]);
      chan_shifted[c]  = chan_sum_next[c] >> eff_shift;
    end
    masked_sum_next = (s1_line_start ? '0 : masked_sum)
                    - MSUM_W'(old_pix & pixel_mask)
                    + MSUM_W'(s1_pixel & pixel_mask);
    masked_shifted  = masked_sum_next >> eff_shift;
  end

  // Result selection.
  always_comb begin
    if (!s1_enable) begin
      blur_pixel = s1_pixel;
    end else if (masked_mode) begin
      blur_pixel = (masked_shifted[PIX_W-1:0] & pixel_mask) | (s1_pixel & ~pixel_mask);
    end else begin
      for (int c = 0; c < NUM_CH; c++) begin
        blur_pixel[c*CH_W +: CH_W] = chan_shifted[c][CH_W-1:0];
      end
      if (eff_shift >= SHIFT_W'(ALPHA_SHIFT_LIMIT)) begin
        blur_pixel[ALPHA_CH*CH_W +: CH_W] = '0;
      end
    end
  end

  // Sum registers commit when a blur-enabled beat leaves the RAM stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CH; c++) begin
        chan_sum[c] <= '0;
      end
      masked_sum <= '0;
    end else if (s1_adv && s1_enable) begin
      for (int c = 0; c < NUM_CH; c++) begin
        chan_sum[c] <= chan_sum_next[c];
      end
      masked_sum <= masked_sum_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_pixel <= blur_pixel;
    end
  end

  assign out_chan.valid     = out_valid;
  assign out_chan.pixel_out = out_pixel;

  // Checks on the line state and the pipeline.
  `RBB_ASSERT_NEXT(a_line_start_pos, in_fire && blur_enable && in_chan.line_start, position == POS_W'(1), "position not restarted at line start")
  `RBB_ASSERT_NEXT(a_bypass_keeps_state, in_fire && !blur_enable, $stable(position) && $stable(window_full), "disabled beat changed line state")
  `RBB_ASSERT_SAME(a_stage_hold, s1_valid && !s1_adv, out_valid && !out_chan.ready, "RAM stage held without output stall")

endmodule

`default_nettype wire
